@@ hw/rtl/text_console_writer_macros.svh @@
// Assertion macros for the text console writer.
// Included by the top level; has no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg)
`define TCW_ASSERT_SAME(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/tcw_pkg.sv @@
// Shared types and constants of the text console writer.
// No dependencies; used by the controller, the datapath and the top level.
package tcw_pkg;

  // Default screen geometry.
  localparam int unsigned COLS_DEF = 80;
  localparam int unsigned ROWS_DEF = 25;

  // Cell and character constants.
  localparam logic [15:0] BLANK_CELL = 16'h0F20;
  localparam logic [7:0]  CH_NL      = 8'h0A;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam int unsigned TAB_STOP   = 4;

  // Operation codes.
  typedef enum logic [1:0] {
    FUNC_PUT    = 2'd0,
    FUNC_SCROLL = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [7:0]  line_count;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_data;
  } rsp_t;

  // Cursor update requested by the controller.
  typedef enum logic [2:0] {
    CUR_NONE   = 3'd0,
    CUR_ADV    = 3'd1,
    CUR_NL     = 3'd2,
    CUR_CR     = 3'd3,
    CUR_SCROLL = 3'd4
  } cur_op_e;

  // Source of the row offset for a store sweep.
  typedef enum logic [1:0] {
    SWP_ROW   = 2'd0,
    SWP_LINES = 2'd1,
    SWP_ALL   = 2'd2
  } sweep_kind_e;

  typedef struct packed {
    logic        item_start;
    logic        rd_req;
    logic [10:0] rd_addr;
    logic        put_we;
    logic [15:0] put_cell;
    cur_op_e     cur_op;
    logic        lines_load;
    logic [7:0]  lines;
    logic        shift_calc;
    logic        sweep_start;
    sweep_kind_e sweep_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic       last_col;
    logic       last_row;
    logic [1:0] col_phase;
    logic       sweep_done;
  } dp_sts_t;

endpackage

@@ hw/rtl/tcw_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tcw_ctrl.sv @@
// Controller of the text console writer: sequences operations, tabs and sweeps.
// Depends on tcw_pkg.
module tcw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  tcw_pkg::req_t    req_i,
  input  tcw_pkg::dp_sts_t sts_i,
  output logic             busy,
  output logic             result_valid_o,
  output tcw_pkg::dp_cmd_t cmd_o
);
  import tcw_pkg::*;

  typedef enum logic [6:0] {
    ST_INIT  = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_TAB   = 7'b0000100,
    ST_MULT  = 7'b0001000,
    ST_SCRL  = 7'b0010000,
    ST_SWEEP = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  state_e     ret_q, ret_d;
  logic [2:0] tab_cnt_q, tab_cnt_d;
  logic [7:0] attr_q, attr_d;
  logic       wrap;

  // A write at the last cell pushes the screen up by one row.
  assign wrap = sts_i.last_col && sts_i.last_row;

  // Next state and datapath commands.
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    tab_cnt_d = tab_cnt_q;
    attr_d    = attr_q;
    cmd_o     = '0;
    cmd_o.rd_addr  = req_i.cell_index;
    cmd_o.lines    = req_i.line_count;
    cmd_o.cur_op   = CUR_NONE;
    cmd_o.sweep_kind = SWP_ROW;
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep_start = 1'b1;
        cmd_o.sweep_kind  = SWP_ALL;
        ret_d   = ST_IDLE;
        state_d = ST_SWEEP;
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.item_start = 1'b1;
          attr_d = req_i.attribute;
          case (req_i.func)
            FUNC_PUT: begin
              case (req_i.char_code)
                CH_NL: begin
                  cmd_o.cur_op = CUR_NL;
                  if (sts_i.last_row) begin
                    cmd_o.sweep_start = 1'b1;
                    ret_d   = ST_DONE;
                    state_d = ST_SWEEP;
                  end else begin
                    state_d = ST_DONE;
                  end
                end
                CH_CR: begin
                  cmd_o.cur_op = CUR_CR;
                  state_d = ST_DONE;
                end
                CH_TAB: begin
                  tab_cnt_d = 3'(TAB_STOP) - {1'b0, sts_i.col_phase};
                  state_d   = ST_TAB;
                end
                default: begin
                  cmd_o.put_we   = 1'b1;
                  cmd_o.put_cell = {req_i.attribute, req_i.char_code};
                  cmd_o.cur_op   = CUR_ADV;
                  if (wrap) begin
                    cmd_o.sweep_start = 1'b1;
                    ret_d   = ST_DONE;
                    state_d = ST_SWEEP;
                  end else begin
                    state_d = ST_DONE;
                  end
                end
              endcase
            end
            FUNC_SCROLL: begin
              if (req_i.line_count == 8'd0) begin
                state_d = ST_DONE;
              end else begin
                cmd_o.lines_load = 1'b1;
                state_d = ST_MULT;
              end
            end
            FUNC_CLEAR: begin
              cmd_o.sweep_start = 1'b1;
              cmd_o.sweep_kind  = SWP_ALL;
              ret_d   = ST_DONE;
              state_d = ST_SWEEP;
            end
            FUNC_READ: begin
              cmd_o.rd_req = 1'b1;
              state_d = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      // One space per cycle until the tab stop is reached; a write to the last cell pauses it for a sweep.
      ST_TAB: begin
        cmd_o.put_we   = 1'b1;
        cmd_o.put_cell = {attr_q, CH_SPACE};
        cmd_o.cur_op   = CUR_ADV;
        tab_cnt_d = tab_cnt_q - 3'd1;
        if (wrap) begin
          cmd_o.sweep_start = 1'b1;
          ret_d   = (tab_cnt_q == 3'd1) ? ST_DONE : ST_TAB;
          state_d = ST_SWEEP;
        end else if (tab_cnt_q == 3'd1) begin
          state_d = ST_DONE;
        end
      end
      ST_MULT: begin
        cmd_o.shift_calc = 1'b1;
        state_d = ST_SCRL;
      end
      ST_SCRL: begin
        cmd_o.sweep_start = 1'b1;
        cmd_o.sweep_kind  = SWP_LINES;
        cmd_o.cur_op      = CUR_SCROLL;
        ret_d   = ST_DONE;
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (sts_i.sweep_done) begin
          state_d = ret_q;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // State registers; the attribute is payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      ret_q     <= ST_IDLE;
      tab_cnt_q <= 3'd0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      tab_cnt_q <= tab_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    attr_q <= attr_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_DONE);

endmodule

@@ hw/rtl/tcw_dpath.sv @@
// Datapath of the text console writer: cursor registers, scroll arithmetic,
// the character store and its sweep engine. Depends on tcw_pkg and tcw_ram.
module tcw_dpath #(
  parameter int unsigned COLS = tcw_pkg::COLS_DEF,
  parameter int unsigned ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcw_pkg::dp_cmd_t cmd_i,
  output tcw_pkg::dp_sts_t sts_o,
  output tcw_pkg::rsp_t    rsp_o
);
  import tcw_pkg::*;

  localparam int unsigned CELLS      = COLS * ROWS;
  localparam int unsigned AW         = $clog2(CELLS);
  localparam int unsigned RW         = $clog2(ROWS);
  localparam int unsigned CLW        = $clog2(COLS);
  localparam int unsigned SW         = $clog2(CELLS + 1);
  localparam int unsigned RPW        = $clog2(2 * CELLS);
  localparam int unsigned LAST_START = CELLS - COLS;

  logic [RW-1:0]  row_q, row_d;
  logic [CLW-1:0] col_q, col_d;
  logic [AW-1:0]  lin_q, lin_d;
  logic [7:0]     lines_q;
  logic [SW-1:0]  shift_q;
  logic           last_col, last_row, row_ge;

  logic           sw_active_q, sw_pend_q, sw_copy_q;
  logic [AW-1:0]  sw_cnt_q, sw_wa_q;
  logic [RPW-1:0] sw_rp_q, sw_shift;
  logic           sw_copy;
  logic           rd_in, rd_hit_q;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [15:0]    ram_wdata, ram_rdata;

  assign last_col = (col_q == CLW'(COLS - 1));
  assign last_row = (row_q == RW'(ROWS - 1));
  assign row_ge   = (8'(row_q) >= lines_q);

  // Cursor update.
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    lin_d = lin_q;
    case (cmd_i.cur_op)
      CUR_NONE: ;
      CUR_ADV: begin
        if (last_col) begin
          col_d = '0;
          if (last_row) begin
            lin_d = AW'(LAST_START);
          end else begin
            row_d = row_q + RW'(1);
            lin_d = lin_q + AW'(1);
          end
        end else begin
          col_d = col_q + CLW'(1);
          lin_d = lin_q + AW'(1);
        end
      end
      CUR_NL: begin
        col_d = '0;
        if (last_row) begin
          lin_d = AW'(LAST_START);
        end else begin
          row_d = row_q + RW'(1);
          lin_d = lin_q - AW'(col_q) + AW'(COLS);
        end
      end
      CUR_CR: begin
        col_d = '0;
        lin_d = lin_q - AW'(col_q);
      end
      CUR_SCROLL: begin
        if (row_ge) begin
          row_d = row_q - RW'(lines_q);
          lin_d = lin_q - AW'(shift_q);
        end else begin
          row_d = '0;
          col_d = '0;
          lin_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      lin_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      lin_q <= lin_d;
    end
  end

  // Scroll count, clamped to the row total, and its offset in cells.
  always_ff @(posedge clk_i) begin
    if (cmd_i.lines_load) begin
      lines_q <= (cmd_i.lines > 8'(ROWS)) ? 8'(ROWS) : cmd_i.lines;
    end
    if (cmd_i.shift_calc) begin
      shift_q <= SW'(int'(lines_q) * COLS);
    end
  end

  // Sweep offset for the requested kind.
  always_comb begin
    case (cmd_i.sweep_kind)
      SWP_ROW:   sw_shift = RPW'(COLS);
      SWP_LINES: sw_shift = RPW'(shift_q);
      SWP_ALL:   sw_shift = RPW'(CELLS);
      default:   sw_shift = RPW'(CELLS);
    endcase
  end

  // The sweep reads cell i plus offset and writes cell i in the cycle after the read;
  // once the read side passes the last cell the writes carry blanks.
  assign sw_copy = (sw_rp_q < RPW'(CELLS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_active_q <= 1'b0;
      sw_pend_q   <= 1'b0;
    end else begin
      sw_pend_q <= sw_active_q;
      if (cmd_i.sweep_start) begin
        sw_active_q <= 1'b1;
      end else if (sw_active_q && (sw_cnt_q == AW'(CELLS - 1))) begin
        sw_active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_start) begin
      sw_cnt_q <= '0;
      sw_rp_q  <= sw_shift;
    end else if (sw_active_q) begin
      sw_cnt_q <= sw_cnt_q + AW'(1);
      sw_rp_q  <= sw_rp_q + RPW'(1);
    end
    sw_wa_q   <= sw_cnt_q;
    sw_copy_q <= sw_copy;
  end

  // Cell read: a hit is remembered for the result of this transfer.
  assign rd_in = (32'(cmd_i.rd_addr) < CELLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_hit_q <= 1'b0;
    end else if (cmd_i.item_start) begin
      rd_hit_q <= cmd_i.rd_req && rd_in;
    end
  end

  // Store port selection; the sweep never overlaps a character write.
  assign ram_we    = sw_pend_q || cmd_i.put_we;
  assign ram_waddr = sw_pend_q ? sw_wa_q : lin_q;
  assign ram_wdata = sw_pend_q ? (sw_copy_q ? ram_rdata : BLANK_CELL) : cmd_i.put_cell;
  assign ram_re    = (sw_active_q && sw_copy) || (cmd_i.rd_req && rd_in);
  assign ram_raddr = sw_active_q ? sw_rp_q[AW-1:0] : AW'(cmd_i.rd_addr);

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Status and result.
  assign sts_o.last_col   = last_col;
  assign sts_o.last_row   = last_row;
  assign sts_o.col_phase  = col_q[1:0];
  assign sts_o.sweep_done = sw_pend_q && !sw_active_q;

  assign rsp_o.cursor_pos = 11'(lin_q);
  assign rsp_o.cell_data  = rd_hit_q ? ram_rdata : 16'h0000;

endmodule

@@ hw/rtl/text_console_writer.sv @@
// Text console writer: put char, newline, return, read and a scroll by zero go from the
// accept in ST_IDLE to the result strobe in ST_DONE; a tab first puts its spaces in ST_TAB.
// Scroll, clear, a newline on the last row and a write to the last cell walk the store
// one cell a cycle in ST_SWEEP before ST_DONE; a scroll first passes ST_MULT and ST_SCRL.
// The next item is taken in the cycle after the strobe, so no item is taken while one is
// in flight. After reset the store is blanked with busy high. The receiver cannot stall.
`include "text_console_writer_macros.svh"

module text_console_writer #(
  parameter int unsigned COLS = tcw_pkg::COLS_DEF,
  parameter int unsigned ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  tcw_pkg::req_t req_i,
  output logic          busy,
  output logic          result_valid_o,
  output tcw_pkg::rsp_t rsp_o
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = COLS * ROWS;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .req_i          (req_i),
    .sts_i          (sts),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd)
  );

  tcw_dpath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

  // Each transfer yields exactly one single-cycle result.
  `TCW_ASSERT_NEXT(a_strobe_single, result_valid_o, !result_valid_o, "result strobe held")
  `TCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not set busy")
  `TCW_ASSERT_SAME(a_cursor_range, result_valid_o, 32'(rsp_o.cursor_pos) < CELLS, "cursor out of range")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the text console writer: drives command transfers,
// predicts every result with its own console model and checks each result strobe.
// Depends on tcw_pkg and the text_console_writer RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int unsigned COLS         = COLS_DEF;
  localparam int unsigned ROWS         = ROWS_DEF;
  localparam int unsigned CELLS        = COLS * ROWS;
  localparam int unsigned RANDOM_ITEMS = 900;
  // Allow several store walks back to back without a transfer.
  localparam int unsigned STALL_LIMIT  = 5 * CELLS + 1000;
  localparam int unsigned TAIL_CYCLES  = CELLS + 16;

  // One queued command with the sender behavior that goes with it.
  typedef struct packed {
    req_t       req;
    logic [6:0] idle_pct;
    logic       drain;
  } cmd_entry_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic result_valid_o;
  rsp_t rsp_o;

  cmd_entry_t  command_q [$];
  rsp_t        report_q [$];

  // Console model state.
  logic [15:0] screen_model [CELLS];
  int unsigned cursor_model;
  int unsigned wrap_scrolls = 0;

  // Bookkeeping.
  int unsigned op_count [4] = '{0, 0, 0, 0};
  int unsigned queued       = 0;
  int unsigned directed     = 0;
  int unsigned reports_seen = 0;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  logic [6:0]  phase_idle   = 7'd0;
  logic        drain_next   = 1'b0;

  text_console_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .req_i         (req_i),
    .busy          (busy),
    .result_valid_o(result_valid_o),
    .rsp_o         (rsp_o)
  );

  // 12 ns clock.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Fill every cell from the given row to the end of the screen with blanks.
  function automatic void blank_from_row(int unsigned row);
    for (int unsigned i = row * COLS; i < CELLS; i++) begin
      screen_model[i] = BLANK_CELL;
    end
  endfunction

  // Move rows up, blank the freed rows and pull the cursor up with them.
  function automatic void scroll_model(int unsigned lines);
    int unsigned n;
    int unsigned shift;
    if (lines == 0) return;
    n = (lines > ROWS) ? ROWS : lines;
    shift = n * COLS;
    for (int unsigned i = 0; i + shift < CELLS; i++) begin
      screen_model[i] = screen_model[i + shift];
    end
    blank_from_row(ROWS - n);
    cursor_model = (cursor_model > shift) ? cursor_model - shift : 0;
    if (cursor_model >= CELLS) cursor_model = CELLS - 1;
  endfunction

  // Store one character under the cursor; running off the end scrolls one row.
  function automatic void write_model(logic [7:0] ch, logic [7:0] attr);
    if (cursor_model < CELLS) screen_model[cursor_model] = {attr, ch};
    cursor_model++;
    if (cursor_model >= CELLS) begin
      wrap_scrolls++;
      scroll_model(1);
    end
  endfunction

  // Apply one command to the console model and return the report it produces.
  function automatic rsp_t console_step(req_t r);
    rsp_t        res;
    int unsigned pad;
    res = '0;
    case (r.func)
      FUNC_PUT: begin
        if (r.char_code == CH_NL) begin
          cursor_model = (cursor_model / COLS + 1) * COLS;
          if (cursor_model >= CELLS) begin
            wrap_scrolls++;
            scroll_model(1);
          end
        end else if (r.char_code == CH_CR) begin
          cursor_model = (cursor_model / COLS) * COLS;
        end else if (r.char_code == CH_TAB) begin
          pad = TAB_STOP - (cursor_model % COLS) % TAB_STOP;
          for (int unsigned i = 0; i < pad; i++) begin
            write_model(CH_SPACE, r.attribute);
          end
        end else begin
          write_model(r.char_code, r.attribute);
        end
      end
      FUNC_SCROLL: scroll_model(r.line_count);
      FUNC_CLEAR:  blank_from_row(0);
      default: begin
        if (r.cell_index < CELLS) res.cell_data = screen_model[r.cell_index];
      end
    endcase
    if (cursor_model >= CELLS) cursor_model = CELLS - 1;
    res.cursor_pos = cursor_model[10:0];
    return res;
  endfunction

  // Append one command with the current sender behavior.
  function automatic void push_cmd(func_e f, logic [7:0] ch, logic [7:0] attr,
                                   logic [7:0] lines, logic [10:0] idx);
    cmd_entry_t e;
    e.req.func       = f;
    e.req.char_code  = ch;
    e.req.attribute  = attr;
    e.req.line_count = lines;
    e.req.cell_index = idx;
    e.idle_pct       = phase_idle;
    e.drain          = drain_next;
    drain_next       = 1'b0;
    command_q.push_back(e);
    queued++;
  endfunction

  // Driver: presents the head of the command queue and predicts on each transfer.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic taken;
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        report_q.push_back(console_step(req_i));
        op_count[int'(req_i.func)]++;
        void'(command_q.pop_front());
      end
      // A command that was not taken stays on the bus unchanged.
      if (!start || taken) begin
        if (command_q.size() == 0) begin
          start <= 1'b0;
        end else if (command_q[0].drain && report_q.size() != 0) begin
          start <= 1'b0;
        end else if ($urandom_range(0, 99) < command_q[0].idle_pct) begin
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          req_i <= command_q[0].req;
        end
      end
    end
  end

  // Monitor: compares each result with the oldest report and runs the watchdog.
  always @(posedge clk_i) begin : check_proc
    rsp_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        reports_seen++;
        if (report_q.size() == 0) begin
          $error("Unexpected result: cursor_pos %0d cell_data %h",
                 rsp_o.cursor_pos, rsp_o.cell_data);
          fail_count++;
        end else begin
          want = report_q.pop_front();
          if (rsp_o.cursor_pos !== want.cursor_pos) begin
            $error("cursor_pos mismatch: expected %0d, got %0d",
                   want.cursor_pos, rsp_o.cursor_pos);
            fail_count++;
          end
          if (rsp_o.cell_data !== want.cell_data) begin
            $error("cell_data mismatch: expected %h, got %h",
                   want.cell_data, rsp_o.cell_data);
            fail_count++;
          end
        end
      end
      if (result_valid_o || (start && !busy)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int unsigned len;
    int unsigned r;
    int unsigned phase;
    int unsigned last_phase;
    logic [7:0]  ch;
    logic [7:0]  line_attr;
    logic [7:0]  cnt;

    blank_from_row(0);
    cursor_model = 0;

    // Directed part: field extremes, every operation and the special cases.
    push_cmd(FUNC_READ, 8'h00, 8'h00, 8'h00, 11'd0);
    push_cmd(FUNC_READ, 8'hFF, 8'hFF, 8'hFF, 11'd1999);
    push_cmd(FUNC_READ, 8'h00, 8'h00, 8'h00, 11'd2000);
    push_cmd(FUNC_READ, 8'hFF, 8'hFF, 8'hFF, 11'd2047);
    push_cmd(FUNC_PUT, 8'h41, 8'hFF, 8'h00, 11'd0);
    push_cmd(FUNC_PUT, 8'h00, 8'h00, 8'hFF, 11'd2047);
    push_cmd(FUNC_PUT, 8'hFF, 8'h80, 8'h00, 11'd0);
    // Tab from column 3 pads one space; from column 4 it pads a full stop.
    push_cmd(FUNC_PUT, CH_TAB, 8'h1E, 8'h00, 11'd0);
    push_cmd(FUNC_PUT, CH_TAB, 8'h07, 8'h00, 11'd0);
    push_cmd(FUNC_READ, 8'h00, 8'h00, 8'h00, 11'd0);
    push_cmd(FUNC_READ, 8'h00, 8'h00, 8'h00, 11'd2);
    push_cmd(FUNC_READ, 8'h00, 8'h00, 8'h00, 11'd3);
    push_cmd(FUNC_PUT, CH_CR, 8'h00, 8'h00, 11'd0);
    push_cmd(FUNC_PUT, CH_NL, 8'h00, 8'h00, 11'd0);
    push_cmd(FUNC_PUT, 8'h78, 8'h2A, 8'h00, 11'd0);
    // Scroll by zero, by one, by exactly the row total and above it.
    push_cmd(FUNC_SCROLL, 8'h00, 8'h00, 8'd0, 11'd0);
    push_cmd(FUNC_SCROLL, 8'h00, 8'h00, 8'd1, 11'd0);
    push_cmd(FUNC_READ, 8'h00, 8'h00, 8'h00, 11'd0);
    push_cmd(FUNC_PUT, 8'h51, 8'h4F, 8'h00, 11'd0);
    push_cmd(FUNC_SCROLL, 8'h00, 8'h00, 8'(ROWS), 11'd0);
    push_cmd(FUNC_PUT, 8'h52, 8'h4F, 8'h00, 11'd0);
    push_cmd(FUNC_SCROLL, 8'h00, 8'h00, 8'd255, 11'd0);
    push_cmd(FUNC_PUT, 8'h53, 8'h4F, 8'h00, 11'd0);
    push_cmd(FUNC_CLEAR, 8'h00, 8'h00, 8'h00, 11'd0);
    push_cmd(FUNC_READ, 8'h00, 8'h00, 8'h00, 11'd0);
    directed = queued;

    // Random part: lines of text with occasional reads, scrolls, clears and noise.
    last_phase = 0;
    while (queued < directed + RANDOM_ITEMS) begin
      phase = ((queued - directed) * 3) / RANDOM_ITEMS;
      phase_idle = (phase == 1) ? 7'd65 : (phase == 2) ? 7'd7 : 7'd0;
      if (phase != last_phase || $urandom_range(0, 99) == 0) drain_next = 1'b1;
      last_phase = phase;

      line_attr = 8'($urandom);
      len = ($urandom_range(0, 99) < 30) ? $urandom_range(60, 170) : $urandom_range(0, 40);
      for (int unsigned k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 80) ch = 8'($urandom_range(8'h21, 8'h7E));
        else if (r < 88) ch = CH_SPACE;
        else if (r < 93) ch = CH_TAB;
        else ch = 8'($urandom);
        push_cmd(FUNC_PUT, ch, ($urandom_range(0, 9) == 0) ? 8'($urandom) : line_attr,
                 8'($urandom), 11'($urandom_range(0, 2047)));
      end

      // Line ending: mostly newline, sometimes a return first or a return alone, or none at all.
      r = $urandom_range(0, 9);
      if (r == 6 || r == 7 || r == 8) begin
        push_cmd(FUNC_PUT, CH_CR, 8'($urandom), 8'($urandom), 11'($urandom_range(0, 2047)));
      end
      if (r <= 7) begin
        push_cmd(FUNC_PUT, CH_NL, 8'($urandom), 8'($urandom), 11'($urandom_range(0, 2047)));
      end

      // Reads favor the bottom row, where most text lands.
      if ($urandom_range(0, 99) < 35) begin
        repeat ($urandom_range(1, 3)) begin
          push_cmd(FUNC_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                   ($urandom_range(0, 1) == 0) ? 11'($urandom_range(CELLS - COLS, CELLS - 1))
                                               : 11'($urandom_range(0, 2047)));
        end
      end
      if ($urandom_range(0, 99) < 8) begin
        cnt = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 3)) : 8'($urandom);
        push_cmd(FUNC_SCROLL, 8'($urandom), 8'($urandom), cnt, 11'($urandom_range(0, 2047)));
      end
      if ($urandom_range(0, 99) < 3) begin
        push_cmd(FUNC_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                 11'($urandom_range(0, 2047)));
      end
      if ($urandom_range(0, 99) < 5) begin
        push_cmd(func_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom),
                 11'($urandom_range(0, 2047)));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (command_q.size() != 0 || report_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d put, %0d scroll, %0d clear and %0d read transfers (%0d directed).",
             op_count[0], op_count[1], op_count[2], op_count[3], directed);
    $display("Checked %0d results, including %0d end-of-screen scrolls.",
             reports_seen, wrap_scrolls);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ text_console_writer.f @@
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_dpath.sv
hw/rtl/text_console_writer.sv
tb/testbench.sv
